// ----- rtl/core/lru_page_buffer_with_pins_core_defines.svh -----
// assertion macros for the page buffer core
// no dependencies
`ifndef LRU_PAGE_BUFFER_WITH_PINS_CORE_DEFINES_SVH
`define LRU_PAGE_BUFFER_WITH_PINS_CORE_DEFINES_SVH
// implication checked every cycle outside reset
`define LPB_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("lpb check failed");
// next-cycle implication
`define LPB_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("lpb check failed");
`endif

// ----- rtl/core/lpb_pkg.sv -----
// shared types and codes of the page buffer core
// no dependencies
package lpb_pkg;
   localparam logic [2:0] OP_PIN = 3'd0, OP_READ = 3'd1, OP_WRITE = 3'd2,
      OP_RELEASE = 3'd3, OP_WREL = 3'd4, OP_FLUSH = 3'd5, OP_RNT = 3'd6,
      OP_UNUSED = 3'd7;
   localparam logic [2:0] ST_OK = 3'd0, ST_ALLPIN = 3'd1, ST_NORES = 3'd2,
      ST_TPIN = 3'd3, ST_UNDER = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  tbl_no;
      logic [31:0] page_no;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic [3:0]  slot;
      logic        fill_needed;
      logic        victim_valid;
      logic [3:0]  victim_table;
      logic [31:0] victim_page;
      logic        victim_writeback;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_FSCAN, S_FDROP, S_EMIT
   } state_type;
endpackage

// ----- rtl/core/lpb_cell.sv -----
// one frame cell of the page buffer: tag, pins, dirty, rank
// depends on lpb_pkg
module lpb_cell (
   input  logic        clock,
   input  logic        reset,
   input  logic        occ,       // slot below frames_used
   input  logic        shift,     // take neighbour's contents
   input  logic [3:0]  nb_table,
   input  logic [31:0] nb_page,
   input  logic        nb_dirty,
   input  logic [7:0]  nb_pins,
   input  logic [5:0]  nb_rank,
   input  logic        load,
   input  logic [3:0]  ld_table,
   input  logic [31:0] ld_page,
   input  logic        clr,       // clear dirty and pins
   input  logic        pin_inc,
   input  logic        pin_dec,
   input  logic        set_dirty,
   input  logic        rank_zero,
   input  logic        rank_inc,
   input  logic        rank_dec,
   output logic [3:0]  q_table,
   output logic [31:0] q_page,
   output logic        q_dirty,
   output logic [7:0]  q_pins,
   output logic [5:0]  q_rank
);
   logic [3:0]  table_ff;
   logic [31:0] page_ff;
   logic        dirty_ff, dirty_in;
   logic [7:0]  pins_ff, pins_in;
   logic [5:0]  rank_ff, rank_in;

   // control part of the cell
   always_comb begin
      dirty_in = dirty_ff;
      pins_in  = pins_ff;
      rank_in  = rank_ff;
      if (shift) begin
         dirty_in = nb_dirty;
         pins_in  = nb_pins;
         rank_in  = nb_rank;
      end
      if (load || clr) begin
         dirty_in = 1'b0;
         pins_in  = 8'd0;
      end
      if (rank_inc) rank_in = rank_in + 6'd1;
      if (rank_dec) rank_in = rank_in - 6'd1;
      if (rank_zero) rank_in = 6'd0;
      if (pin_inc && pins_in != 8'hFF) pins_in = pins_in + 8'd1;
      if (pin_dec && pins_in != 8'd0) pins_in = pins_in - 8'd1;
      if (set_dirty) dirty_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= 1'b0;
         pins_ff  <= 8'd0;
      end else begin
         dirty_ff <= dirty_in;
         pins_ff  <= pins_in;
      end
   end

   // tag and rank payload
   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
      if (load) begin
         table_ff <= ld_table;
         page_ff  <= ld_page;
      end else if (shift) begin
         table_ff <= nb_table;
         page_ff  <= nb_page;
      end
   end

   assign q_table = table_ff;
   assign q_page  = page_ff;
   assign q_dirty = dirty_ff;
   assign q_pins  = occ ? pins_ff : pins_ff;
   assign q_rank  = rank_ff;
endmodule

// ----- rtl/core/lru_page_buffer_with_pins_core.sv -----
// top level of the page buffer tag and policy store
// depends on lpb_pkg, lpb_cell and the defines header
`include "lru_page_buffer_with_pins_core_defines.svh"
// Usage: a request beat (op, table, page) is taken when start is high and
// busy is low. Results appear on rsp_data, one cycle each, with rsp_valid;
// the receiver cannot stall, so each result is gone after its cycle.
// The capacity register is written on csr_valid with csr_ready high, which
// holds only while idle.
// Sequence: a lookup scans the occupied slots one per cycle up to the end
// test, then passes the decide state and the result state, and busy falls
// on return to idle. A miss in a full pool goes from decide back to a second
// scan for the LRU victim, then takes an eviction step and an insert step in
// the decide state before the result state. The next request is taken only
// in the idle state, so a new request cannot begin before the last is through.
// Flush scans slot by slot; each removed entry is dropped with a compaction
// and then given out as a result beat, the scan resuming at the same slot.
// In the compaction, the dropped slot and every occupied cell above it but
// the topmost take their upper neighbour; the topmost loses pins and dirty.
// Reset empties the pool (frames_used zero, pins and dirty cleared) and
// sets the capacity to 16.
module lru_page_buffer_with_pins_core #(
   parameter int FRAMES = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  lpb_pkg::req_type req_data,
   output logic            rsp_valid,
   output lpb_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [4:0]      csr_data
);
   localparam int IW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES + 1);

   lpb_pkg::state_type state_ff, state_in;
   lpb_pkg::req_type   req_ff;
   lpb_pkg::rsp_type   rsp_ff, rsp_in;
   logic [4:0]    cap_reg_ff;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic          vic_ff, vic_in;     // victim search phase
   logic          bfound_ff, bfound_in;
   logic [IW-1:0] best_ff, best_in;
   logic          emit_last_ff, emit_last_in;

   logic [3:0]  q_table [FRAMES];
   logic [31:0] q_page  [FRAMES];
   logic        q_dirty [FRAMES];
   logic [7:0]  q_pins  [FRAMES];
   logic [5:0]  q_rank  [FRAMES];

   // per-cell control
   logic [FRAMES-1:0] c_shift, c_load, c_clr, c_pinc, c_pdec, c_sdirty;
   logic [FRAMES-1:0] c_rz, c_rinc, c_rdec, c_occ;

   // cell action request, taken into the cell registers
   logic          act_drop, act_insert, act_touch, act_pin, act_unpin, act_dirty;
   logic [IW-1:0] act_slot;
   logic [CW-1:0] cap;

   always_comb begin
      cap = CW'(cap_reg_ff);
      if (cap_reg_ff == 5'd0) cap = CW'(1);
      if ({27'd0, cap_reg_ff} > 32'(FRAMES)) cap = CW'(FRAMES);
   end

   logic [IW-1:0] sidx;
   assign sidx = idx_ff[IW-1:0];
   logic hit_now;
   assign hit_now = q_table[sidx] == req_ff.tbl_no && q_page[sidx] == req_ff.page_no;
   logic scan_end;
   assign scan_end = idx_ff >= used_ff;

   // next state and sequencing
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff; found_in = found_ff; fidx_in = fidx_ff;
      vic_in = vic_ff; bfound_in = bfound_ff; best_in = best_ff;
      used_in = used_ff; rsp_in = '0; emit_last_in = emit_last_ff;
      act_drop = 1'b0; act_insert = 1'b0; act_touch = 1'b0;
      act_pin = 1'b0; act_unpin = 1'b0; act_dirty = 1'b0;
      act_slot = '0;
      unique case (state_ff)
         lpb_pkg::S_IDLE: begin
            if (start) begin
               idx_in = '0; found_in = 1'b0; vic_in = 1'b0; bfound_in = 1'b0;
               if (req_data.op == lpb_pkg::OP_FLUSH) state_in = lpb_pkg::S_FSCAN;
               else if (req_data.op == lpb_pkg::OP_UNUSED) begin
                  rsp_in.last = 1'b1; state_in = lpb_pkg::S_EMIT;
               end else state_in = lpb_pkg::S_SCAN;
            end
         end
         lpb_pkg::S_SCAN: begin
            if (scan_end) state_in = lpb_pkg::S_DECIDE;
            else begin
               if (!vic_ff) begin
                  if (hit_now && !found_ff) begin
                     found_in = 1'b1; fidx_in = sidx;
                  end
               end else if (q_pins[sidx] == 8'd0 &&
                            (!bfound_ff || q_rank[sidx] > q_rank[best_ff])) begin
                  bfound_in = 1'b1; best_in = sidx;
               end
               idx_in = idx_ff + CW'(1);
            end
         end
         lpb_pkg::S_DECIDE: begin
            state_in = lpb_pkg::S_EMIT;
            rsp_in.last = 1'b1;
            if (req_ff.op == lpb_pkg::OP_RELEASE || req_ff.op == lpb_pkg::OP_WREL) begin
               if (!found_ff) rsp_in.status = lpb_pkg::ST_NORES;
               else begin
                  rsp_in.hit = 1'b1; rsp_in.slot = 4'(fidx_ff);
                  act_slot = fidx_ff; act_unpin = 1'b1;
                  act_dirty = req_ff.op == lpb_pkg::OP_WREL;
                  if (q_pins[fidx_ff] == 8'd0) rsp_in.status = lpb_pkg::ST_UNDER;
               end
            end else if (found_ff) begin
               rsp_in.hit = 1'b1; rsp_in.slot = 4'(fidx_ff);
               act_slot = fidx_ff;
               act_pin = req_ff.op == lpb_pkg::OP_PIN;
               act_dirty = req_ff.op == lpb_pkg::OP_WRITE;
               act_touch = req_ff.op != lpb_pkg::OP_RNT;
            end else if (used_ff >= cap && !vic_ff && !emit_last_ff) begin
               vic_in = 1'b1; idx_in = '0; state_in = lpb_pkg::S_SCAN;
            end else if (vic_ff && !bfound_ff) begin
               rsp_in.status = lpb_pkg::ST_ALLPIN;
            end else begin
               // optional eviction then insert at the top, done in two steps
               if (vic_ff) begin
                  rsp_in.victim_valid = 1'b1;
                  rsp_in.victim_table = q_table[best_ff];
                  rsp_in.victim_page = q_page[best_ff];
                  rsp_in.victim_writeback = q_dirty[best_ff];
                  act_drop = 1'b1; act_slot = best_ff;
                  used_in = used_ff - CW'(1);
                  vic_in = 1'b0; bfound_in = 1'b0; found_in = 1'b0;
                  state_in = lpb_pkg::S_DECIDE;
                  // carry victim in rsp register across the insert cycle
                  rsp_in.last = 1'b0;
               end else if (used_ff >= CW'(FRAMES)) begin
                  rsp_in.status = lpb_pkg::ST_ALLPIN;
               end else begin
                  rsp_in = rsp_ff;
                  rsp_in.status = lpb_pkg::ST_OK;
                  rsp_in.slot = 4'(used_ff);
                  rsp_in.fill_needed = 1'b1; rsp_in.hit = 1'b0; rsp_in.last = 1'b1;
                  act_insert = 1'b1; act_slot = used_ff[IW-1:0];
                  act_pin = req_ff.op == lpb_pkg::OP_PIN;
                  act_dirty = req_ff.op == lpb_pkg::OP_WRITE;
                  used_in = used_ff + CW'(1);
               end
            end
         end
         lpb_pkg::S_FSCAN: begin
            if (scan_end) begin
               rsp_in.last = 1'b1; state_in = lpb_pkg::S_EMIT;
            end else if (q_table[sidx] == req_ff.tbl_no) begin
               if (q_pins[sidx] != 8'd0) begin
                  rsp_in.last = 1'b1; rsp_in.status = lpb_pkg::ST_TPIN;
                  state_in = lpb_pkg::S_EMIT;
               end else begin
                  rsp_in.victim_valid = 1'b1;
                  rsp_in.victim_table = q_table[sidx];
                  rsp_in.victim_page = q_page[sidx];
                  rsp_in.victim_writeback = q_dirty[sidx];
                  act_drop = 1'b1; act_slot = sidx;
                  used_in = used_ff - CW'(1);
                  state_in = lpb_pkg::S_FDROP;
               end
            end else idx_in = idx_ff + CW'(1);
         end
         lpb_pkg::S_FDROP: state_in = lpb_pkg::S_FSCAN;
         lpb_pkg::S_EMIT: state_in = lpb_pkg::S_IDLE;
         default: state_in = lpb_pkg::S_IDLE;
      endcase
      // a non-final victim beat from decide waits in rsp_ff
      if (state_ff == lpb_pkg::S_DECIDE && act_drop) emit_last_in = 1'b1;
      else if (state_ff == lpb_pkg::S_DECIDE) emit_last_in = 1'b0;
   end

   // outputs: strobe for flush entries and final beats
   assign rsp_valid = state_ff == lpb_pkg::S_EMIT || state_ff == lpb_pkg::S_FDROP;
   assign rsp_data  = rsp_ff;
   assign busy      = state_ff != lpb_pkg::S_IDLE;
   assign csr_ready = state_ff == lpb_pkg::S_IDLE && !start;

   // cell controls from the action request
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         c_occ[i]    = CW'(i) < used_ff;
         c_shift[i]  = act_drop && IW'(i) >= act_slot && CW'(i + 1) < used_ff;
         c_clr[i]    = act_drop && CW'(i + 1) == used_ff;
         c_load[i]   = act_insert && IW'(i) == act_slot;
         c_pinc[i]   = act_pin && IW'(i) == act_slot;
         c_pdec[i]   = act_unpin && IW'(i) == act_slot;
         c_sdirty[i] = act_dirty && IW'(i) == act_slot;
         c_rz[i]     = (act_insert || act_touch) && IW'(i) == act_slot;
         c_rinc[i]   = c_occ[i] && ((act_insert) ||
                       (act_touch && q_rank[i] < q_rank[act_slot]));
         c_rdec[i]   = act_drop && q_rank[(IW'(i) >= act_slot && CW'(i + 1) < used_ff)
                       ? IW'(i + 1) : IW'(i)] > q_rank[act_slot] && c_occ[i];
      end
   end

   // the row of cells; on compaction, cells from the dropped slot up take their upper neighbour
   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      localparam int N = (g + 1 < FRAMES) ? g + 1 : g;
      lpb_cell u_cell (
         .clock(clock), .reset(reset), .occ(c_occ[g]), .shift(c_shift[g]),
         .nb_table(q_table[N]), .nb_page(q_page[N]), .nb_dirty(q_dirty[N]),
         .nb_pins(q_pins[N]), .nb_rank(q_rank[N]),
         .load(c_load[g]), .ld_table(req_ff.tbl_no), .ld_page(req_ff.page_no),
         .clr(c_clr[g]), .pin_inc(c_pinc[g]), .pin_dec(c_pdec[g]),
         .set_dirty(c_sdirty[g]), .rank_zero(c_rz[g]), .rank_inc(c_rinc[g]),
         .rank_dec(c_rdec[g]),
         .q_table(q_table[g]), .q_page(q_page[g]), .q_dirty(q_dirty[g]),
         .q_pins(q_pins[g]), .q_rank(q_rank[g])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpb_pkg::S_IDLE;
         used_ff <= '0;
         cap_reg_ff <= 5'd16;
         emit_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         emit_last_ff <= emit_last_in;
         if (csr_valid && csr_ready) cap_reg_ff <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == lpb_pkg::S_IDLE && start) req_ff <= req_data;
      idx_ff <= idx_in; found_ff <= found_in; fidx_ff <= fidx_in;
      vic_ff <= vic_in; bfound_ff <= bfound_in; best_ff <= best_in;
      if (state_ff != lpb_pkg::S_SCAN && state_ff != lpb_pkg::S_FDROP &&
          !(state_ff == lpb_pkg::S_FSCAN && state_in == lpb_pkg::S_FSCAN))
         rsp_ff <= rsp_in;
   end

   `LPB_ASSERT_IMP(a_used_max, clock, reset, 1'b1, used_ff <= CW'(FRAMES))
   `LPB_ASSERT_IMP(a_no_start_busy, clock, reset, busy, !csr_ready)
   `LPB_ASSERT_NXT(a_emit_idle, clock, reset, state_ff == lpb_pkg::S_EMIT, !busy)
   `LPB_ASSERT_IMP(a_last_final, clock, reset, state_ff == lpb_pkg::S_EMIT, rsp_data.last)
endmodule

// ----- tb/lru_page_buffer_with_pins_core_checker.sv -----
// checker for the page buffer core: predicts every response beat and compares
// depends on lpb_pkg
module lru_page_buffer_with_pins_core_checker #(
   parameter int FRAMES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  lpb_pkg::req_type req_data,
   input  logic    rsp_valid,
   input  lpb_pkg::rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic [4:0] csr_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // model copy of the tag store
   logic [3:0]  pool_tbl  [FRAMES];
   logic [31:0] pool_page [FRAMES];
   logic        pool_dirty[FRAMES];
   logic [7:0]  pool_pins [FRAMES];
   int          pool_rank [FRAMES];
   int          pool_used;
   logic [4:0]  pool_cap_reg;
   lpb_pkg::rsp_type resp_q[$];

   function automatic int pool_capacity();
      int c;
      c = int'(pool_cap_reg);
      if (c == 0) c = 1;
      if (c > FRAMES) c = FRAMES;
      return c;
   endfunction

   function automatic int find_page(logic [3:0] tbl, logic [31:0] pg);
      for (int i = 0; i < pool_used; i++)
         if (pool_tbl[i] == tbl && pool_page[i] == pg) return i;
      return -1;
   endfunction

   // remove one slot and close the gap
   task automatic remove_slot(int s);
      int r;
      r = pool_rank[s];
      for (int i = 0; i < pool_used; i++)
         if (pool_rank[i] > r) pool_rank[i]--;
      for (int i = s; i + 1 < pool_used; i++) begin
         pool_tbl[i]   = pool_tbl[i+1];
         pool_page[i]  = pool_page[i+1];
         pool_dirty[i] = pool_dirty[i+1];
         pool_pins[i]  = pool_pins[i+1];
         pool_rank[i]  = pool_rank[i+1];
      end
      if (pool_used > 0) begin
         pool_used--;
         pool_dirty[pool_used] = 1'b0;
         pool_pins[pool_used]  = '0;
      end
   endtask

   task automatic touch_slot(int s);
      int r;
      r = pool_rank[s];
      for (int i = 0; i < pool_used; i++)
         if (pool_rank[i] < r) pool_rank[i]++;
      pool_rank[s] = 0;
   endtask

   function automatic lpb_pkg::rsp_type final_beat(logic [2:0] st);
      lpb_pkg::rsp_type b;
      b = '0;
      b.status = st;
      b.last = 1'b1;
      return b;
   endfunction

   // work out the response beats of one request
   task automatic predict_request(lpb_pkg::req_type rq);
      lpb_pkg::rsp_type b, v;
      int idx, best;
      b = '0;
      b.last = 1'b1;
      unique case (rq.op)
         lpb_pkg::OP_PIN, lpb_pkg::OP_READ, lpb_pkg::OP_WRITE, lpb_pkg::OP_RNT: begin
            b.hit = 1'b1;
            idx = find_page(rq.tbl_no, rq.page_no);
            if (idx < 0) begin
               if (pool_used >= pool_capacity()) begin
                  best = -1;
                  for (int i = 0; i < pool_used; i++)
                     if (pool_pins[i] == 0 && (best < 0 || pool_rank[i] > pool_rank[best]))
                        best = i;
                  if (best < 0) begin
                     resp_q.push_back(final_beat(lpb_pkg::ST_ALLPIN));
                     return;
                  end
                  b.victim_valid     = 1'b1;
                  b.victim_table     = pool_tbl[best];
                  b.victim_page      = pool_page[best];
                  b.victim_writeback = pool_dirty[best];
                  remove_slot(best);
               end
               if (pool_used >= FRAMES) begin
                  resp_q.push_back(final_beat(lpb_pkg::ST_ALLPIN));
                  return;
               end
               for (int i = 0; i < pool_used; i++) pool_rank[i]++;
               idx = pool_used;
               pool_tbl[idx]   = rq.tbl_no;
               pool_page[idx]  = rq.page_no;
               pool_dirty[idx] = 1'b0;
               pool_pins[idx]  = '0;
               pool_rank[idx]  = 0;
               pool_used++;
               b.hit = 1'b0;
               b.fill_needed = 1'b1;
            end
            if (rq.op == lpb_pkg::OP_PIN && pool_pins[idx] != 8'hff) pool_pins[idx]++;
            if (rq.op == lpb_pkg::OP_WRITE) pool_dirty[idx] = 1'b1;
            if (rq.op != lpb_pkg::OP_RNT) touch_slot(idx);
            b.slot = idx[3:0];
            resp_q.push_back(b);
         end
         lpb_pkg::OP_RELEASE, lpb_pkg::OP_WREL: begin
            idx = find_page(rq.tbl_no, rq.page_no);
            if (idx < 0) begin
               resp_q.push_back(final_beat(lpb_pkg::ST_NORES));
               return;
            end
            if (rq.op == lpb_pkg::OP_WREL) pool_dirty[idx] = 1'b1;
            if (pool_pins[idx] == 0) b.status = lpb_pkg::ST_UNDER;
            else pool_pins[idx]--;
            b.hit = 1'b1;
            b.slot = idx[3:0];
            resp_q.push_back(b);
         end
         lpb_pkg::OP_FLUSH: begin
            // stops at the first pinned entry of the table
            idx = 0;
            b.status = lpb_pkg::ST_OK;
            while (idx < pool_used) begin
               if (pool_tbl[idx] == rq.tbl_no) begin
                  if (pool_pins[idx] != 0) begin
                     b.status = lpb_pkg::ST_TPIN;
                     break;
                  end
                  v = '0;
                  v.victim_valid     = 1'b1;
                  v.victim_table     = pool_tbl[idx];
                  v.victim_page      = pool_page[idx];
                  v.victim_writeback = pool_dirty[idx];
                  resp_q.push_back(v);
                  remove_slot(idx);
               end else begin
                  idx++;
               end
            end
            resp_q.push_back(final_beat(b.status));
         end
         default: resp_q.push_back(final_beat(lpb_pkg::ST_OK));
      endcase
   endtask

   function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v === act_v) return 0;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      return 1;
   endfunction

   // compare first, then take in the new request
   always @(posedge clock) begin
      lpb_pkg::rsp_type e;
      int errs;
      if (reset) begin
         pool_used = 0;
         pool_cap_reg = 5'd16;
         for (int i = 0; i < FRAMES; i++) begin
            pool_dirty[i] = 1'b0;
            pool_pins[i] = '0;
            pool_rank[i] = 0;
         end
         resp_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (resp_q.size() == 0) begin
               $display("%0t: unexpected response beat, expected none, actual %p",
                  $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = resp_q.pop_front();
               errs = field_diff("status", 32'(e.status), 32'(rsp_data.status))
                  + field_diff("hit", 32'(e.hit), 32'(rsp_data.hit))
                  + field_diff("slot", 32'(e.slot), 32'(rsp_data.slot))
                  + field_diff("fill_needed", 32'(e.fill_needed),
                       32'(rsp_data.fill_needed))
                  + field_diff("victim_valid", 32'(e.victim_valid),
                       32'(rsp_data.victim_valid))
                  + field_diff("victim_table", 32'(e.victim_table),
                       32'(rsp_data.victim_table))
                  + field_diff("victim_page", e.victim_page, rsp_data.victim_page)
                  + field_diff("victim_writeback", 32'(e.victim_writeback),
                       32'(rsp_data.victim_writeback))
                  + field_diff("last", 32'(e.last), 32'(rsp_data.last));
               if (errs != 0) fail_count <= fail_count + 1;
            end
         end
         if (csr_valid && csr_ready) pool_cap_reg = csr_data;
         if (start && !busy) predict_request(req_data);
      end
      pending <= resp_q.size();
   end
endmodule

// ----- tb/lru_page_buffer_with_pins_core_test.sv -----
// stimulus and verdict for the page buffer core
// depends on lpb_pkg, the core and lru_page_buffer_with_pins_core_checker
module lru_page_buffer_with_pins_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   lpb_pkg::req_type req_data = '0;
   logic       rsp_valid;
   lpb_pkg::rsp_type rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [4:0] csr_data = '0;
   int         fail_count;
   int         pending;
   int         idle_cycles = 0;
   int         max_gap = 6;

   always #4 clock = ~clock;

   lru_page_buffer_with_pins_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   lru_page_buffer_with_pins_core_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one request beat, after a random gap
   task automatic send(logic [2:0] op, logic [3:0] tbl, logic [31:0] pg);
      int gap;
      lpb_pkg::req_type rq;
      gap = $urandom_range(max_gap, 0);
      rq.op = op;
      rq.tbl_no = tbl;
      rq.page_no = pg;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
   endtask

   // capacity write once all expected responses have arrived
   task automatic set_capacity(logic [4:0] cap);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly a small working set so hits, pins and evictions happen
   task automatic random_phase(int n);
      logic [2:0]  op;
      logic [3:0]  tbl;
      logic [31:0] pg;
      int pick;
      max_gap = ($urandom_range(3, 0) == 0) ? 0 : 6;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99, 0);
         if (pick < 20) op = lpb_pkg::OP_PIN;
         else if (pick < 35) op = lpb_pkg::OP_READ;
         else if (pick < 47) op = lpb_pkg::OP_WRITE;
         else if (pick < 67) op = lpb_pkg::OP_RELEASE;
         else if (pick < 77) op = lpb_pkg::OP_WREL;
         else if (pick < 85) op = lpb_pkg::OP_FLUSH;
         else if (pick < 97) op = lpb_pkg::OP_RNT;
         else op = lpb_pkg::OP_UNUSED;
         tbl = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 0))
                                         : 4'($urandom_range(3, 1));
         pg = ($urandom_range(9, 0) == 0) ? $urandom() : 32'($urandom_range(5, 0));
         send(op, tbl, pg);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: hits, misses, underflow, absent page, flush on a pin, odd op
      send(lpb_pkg::OP_PIN, 4'd1, 32'd0);
      send(lpb_pkg::OP_PIN, 4'd1, 32'd0);
      send(lpb_pkg::OP_READ, 4'd2, 32'hffffffff);
      send(lpb_pkg::OP_WRITE, 4'd10, 32'd5);
      send(lpb_pkg::OP_RNT, 4'd3, 32'd7);
      send(lpb_pkg::OP_RELEASE, 4'd1, 32'd0);
      send(lpb_pkg::OP_RELEASE, 4'd1, 32'd0);
      send(lpb_pkg::OP_RELEASE, 4'd1, 32'd0);
      send(lpb_pkg::OP_WREL, 4'd10, 32'd5);
      send(lpb_pkg::OP_RELEASE, 4'd4, 32'd9);
      send(lpb_pkg::OP_PIN, 4'd1, 32'd1);
      send(lpb_pkg::OP_FLUSH, 4'd1, 32'd0);
      send(lpb_pkg::OP_RELEASE, 4'd1, 32'd1);
      send(lpb_pkg::OP_FLUSH, 4'd1, 32'hffffffff);
      send(lpb_pkg::OP_FLUSH, 4'd10, 32'd0);
      send(lpb_pkg::OP_UNUSED, 4'd15, 32'h5a5a5a5a);
      send(lpb_pkg::OP_READ, 4'd15, 32'h0);
      send(lpb_pkg::OP_READ, 4'd0, 32'ha5a5a5a5);

      // capacity one: a pin, a release and misses that evict the LRU unpinned frame
      set_capacity(5'd1);
      send(lpb_pkg::OP_PIN, 4'd5, 32'd1);
      send(lpb_pkg::OP_READ, 4'd5, 32'd2);
      send(lpb_pkg::OP_RELEASE, 4'd5, 32'd1);
      send(lpb_pkg::OP_WRITE, 4'd5, 32'd2);
      send(lpb_pkg::OP_READ, 4'd5, 32'd3);

      random_phase(60);
      set_capacity(5'd4);
      random_phase(70);
      set_capacity(5'd0);
      random_phase(40);
      set_capacity(5'd31);
      random_phase(70);
      set_capacity(5'd2);
      random_phase(60);
      set_capacity(5'd16);
      random_phase(60);
      set_capacity(5'd9);
      random_phase(50);

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lpb_pkg.sv
rtl/core/lpb_cell.sv
rtl/core/lru_page_buffer_with_pins_core.sv
tb/lru_page_buffer_with_pins_core_checker.sv
tb/lru_page_buffer_with_pins_core_test.sv
